// File: rtl/sgr_mouse_report_decoder_unit_assert.svh
// Assertion macros used by the checker file of the mouse report decoder.
`ifndef SGR_MOUSE_REPORT_DECODER_UNIT_ASSERT_SVH
`define SGR_MOUSE_REPORT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMRD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/smrd_pkg.sv
package smrd_pkg;

  // Canvas geometry.
  localparam int CANVAS_WIDTH  = 480;
  localparam int CANVAS_HEIGHT = 320;
  localparam int CANVAS_MAX    = (CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH : CANVAS_HEIGHT;
  localparam int ZOOM_MAX      = 15;

  // Datapath widths.
  localparam int PARAM_W     = 16;
  localparam int PARAM_ACC_W = 20;
  localparam int PARAM_MAX   = 65535;
  localparam int CB_W        = 9;
  localparam int POS_W       = 9;
  localparam int PROD_W      = 26;
  localparam int DIFF_W      = 27;
  localparam int SIZE_W      = $clog2(CANVAS_MAX + 1);
  localparam int QUO_W       = $clog2(CANVAS_MAX);
  localparam int REM_W       = $clog2(CANVAS_MAX * ZOOM_MAX + 1);
  localparam int STEP_W      = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  // Report queue between the scanner and the mapper.
  localparam int QUEUE_DEPTH = 2;

  // Port widths.
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_W     = 32;
  localparam int TDATA_USED  = 26;
  localparam int TUSER_W     = 3;

  // Byte codes seen by the scanner.
  localparam logic [7:0] BYTE_ESC       = 8'h1b;
  localparam logic [7:0] BYTE_BRACKET   = 8'h5b;
  localparam logic [7:0] BYTE_SGR_MARK  = 8'h3c;
  localparam logic [7:0] BYTE_SEMI      = 8'h3b;
  localparam logic [7:0] BYTE_PRESS     = 8'h4d;
  localparam logic [7:0] BYTE_RELEASE   = 8'h6d;
  localparam logic [7:0] BYTE_DIGIT0    = 8'h30;
  localparam logic [7:0] BYTE_DIGIT9    = 8'h39;
  localparam logic [7:0] BYTE_PARAM_LO  = 8'h20;
  localparam logic [7:0] BYTE_PARAM_HI  = 8'h3f;
  localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
  localparam logic [7:0] BYTE_FINAL_HI  = 8'h7e;

  // Bit positions inside the button code.
  localparam int CB_SHIFT  = 2;
  localparam int CB_ALT    = 3;
  localparam int CB_CTRL   = 4;
  localparam int CB_MOTION = 5;
  localparam int CB_WHEEL  = 6;
  localparam int CB_EXTRA  = 7;
  localparam int CB_LEAVE  = 8;

  localparam logic [1:0] BUTTON_NONE  = 2'd0;
  localparam logic [1:0] BUTTON_THREE = 2'd3;

  localparam logic signed [1:0] WHEEL_NONE = 2'sb00;
  localparam logic signed [1:0] WHEEL_UP   = 2'sb01;
  localparam logic signed [1:0] WHEEL_DOWN = 2'sb11;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_MOVE    = 3'd2,
    EV_WHEEL   = 3'd3,
    EV_LEAVE   = 3'd4
  } event_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TERM_COLS  = 3'd0,
    CFG_TERM_ROWS  = 3'd1,
    CFG_CELL_SIZE  = 3'd2,
    CFG_ORIGIN_COL = 3'd3,
    CFG_ORIGIN_ROW = 3'd4,
    CFG_ZOOM       = 3'd5,
    CFG_OFFSET_X   = 3'd6,
    CFG_OFFSET_Y   = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [9:0]  screen_cols;
    logic [9:0]  screen_rows;
    logic [15:0] cell_size;
    logic [9:0]  image_col;
    logic [9:0]  image_row;
    logic [3:0]  zoom;
    logic [11:0] offset_x;
    logic [11:0] offset_y;
  } cfg_t;

  // One complete report as parsed by the scanner.
  typedef struct packed {
    logic               press;
    logic [CB_W-1:0]    cb;
    logic [PARAM_W-1:0] x;
    logic [PARAM_W-1:0] y;
  } report_t;

  // One decoded mouse event.
  typedef struct packed {
    event_kind_t       kind;
    logic [1:0]        button;
    logic signed [1:0] wheel;
    logic [2:0]        mods;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              in_view;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/smrd_scanner.sv
module smrd_scanner import smrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [BYTE_W-1:0] byte_data,
  input  queue_status_t     q_status,
  output logic              push,
  output report_t           push_data
);

  typedef enum logic [2:0] {
    ST_GROUND,
    ST_ESC,
    ST_CSI,
    ST_SKIP,
    ST_PARAMS
  } scan_state_t;

  scan_state_t          state, state_next;
  logic [PARAM_W-1:0]   params [3];
  logic [PARAM_W-1:0]   params_next [3];
  logic [1:0]           param_index, param_index_next;
  logic [2:0]           seen, seen_next;
  logic [1:0]           idx;
  logic [PARAM_ACC_W-1:0] acc;
  logic                 take;
  logic                 is_digit;

  // Next-state logic for the escape sequence scanner.
  always_comb begin
    byte_ready = !q_status.full;
    take = byte_valid && byte_ready;
    idx = (param_index > 2'd2) ? 2'd2 : param_index;
    is_digit = (byte_data >= BYTE_DIGIT0) && (byte_data <= BYTE_DIGIT9);
    acc = PARAM_ACC_W'({params[idx], 3'b000}) + PARAM_ACC_W'({params[idx], 1'b0})
        + PARAM_ACC_W'(byte_data - BYTE_DIGIT0);

    state_next = state;
    params_next = params;
    param_index_next = param_index;
    seen_next = seen;
    push = 1'b0;
    push_data = '{press: (byte_data == BYTE_PRESS), cb: params[0][CB_W-1:0],
                  x: params[1], y: params[2]};

    if (take) begin
      unique case (state)
        ST_GROUND: begin
          if (byte_data == BYTE_ESC) state_next = ST_ESC;
        end
        ST_ESC: begin
          if (byte_data == BYTE_BRACKET) state_next = ST_CSI;
          else if (byte_data != BYTE_ESC) state_next = ST_GROUND;
        end
        ST_CSI: begin
          if (byte_data == BYTE_SGR_MARK) begin
            params_next[0] = '0;
            params_next[1] = '0;
            params_next[2] = '0;
            seen_next = '0;
            param_index_next = '0;
            state_next = ST_PARAMS;
          end else if (byte_data == BYTE_ESC) begin
            state_next = ST_ESC;
          end else if (byte_data >= BYTE_PARAM_LO && byte_data <= BYTE_PARAM_HI) begin
            state_next = ST_SKIP;
          end else begin
            state_next = ST_GROUND;
          end
        end
        ST_SKIP: begin
          if (byte_data >= BYTE_FINAL_LO && byte_data <= BYTE_FINAL_HI) state_next = ST_GROUND;
          else if (byte_data == BYTE_ESC) state_next = ST_ESC;
        end
        ST_PARAMS: begin
          if (is_digit) begin
            // Decimal accumulate with saturation.
            params_next[idx] = (acc > PARAM_ACC_W'(PARAM_MAX)) ? PARAM_W'(PARAM_MAX)
                                                                : acc[PARAM_W-1:0];
            seen_next[idx] = 1'b1;
          end else if (byte_data == BYTE_SEMI) begin
            // An empty parameter or a fourth one turns the report into a skipped sequence.
            if (!seen[idx] || idx >= 2'd2) state_next = ST_SKIP;
            else param_index_next = idx + 2'd1;
          end else if (byte_data == BYTE_PRESS || byte_data == BYTE_RELEASE) begin
            state_next = ST_GROUND;
            push = (idx == 2'd2) && (seen == 3'b111);
          end else if (byte_data == BYTE_ESC) begin
            state_next = ST_ESC;
          end else begin
            state_next = ST_GROUND;
          end
        end
        default: state_next = ST_GROUND;
      endcase
    end
  end

  // Scanner registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_GROUND;
      param_index <= '0;
      seen <= '0;
    end else begin
      state <= state_next;
      param_index <= param_index_next;
      seen <= seen_next;
    end
    params <= params_next;
  end

endmodule

// File: rtl/smrd_queue.sv
module smrd_queue import smrd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  report_t       push_data,
  input  logic          pop,
  output report_t       head,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  report_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  // Occupancy flags and head entry.
  always_comb begin
    status.full = (count == CNT_W'(QUEUE_DEPTH));
    status.empty = (count == '0);
    head = entries[rd_ptr];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/smrd_mapper.sv
module smrd_mapper import smrd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  queue_status_t q_status,
  input  report_t       q_head,
  output logic          q_pop,
  output logic          ev_valid,
  input  logic          ev_ready,
  output event_t        ev
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_DECIDE,
    M_MUL,
    M_ADD,
    M_CHK,
    M_DIV,
    M_AXEND,
    M_EMIT
  } map_state_t;

  localparam logic signed [DIFF_W-1:0] ONE_S = DIFF_W'(1);

  map_state_t                state;
  report_t                   rep;
  logic                      pixel_mode;
  logic [POS_W-1:0]          last_x, last_y;
  logic                      last_visible;
  logic                      axis;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W-1:0]  diff;
  logic [REM_W-1:0]          rem, dvs;
  logic [QUO_W-1:0]          quo, res, gx;
  logic [STEP_W-1:0]         step;
  logic                      in_axis, vx;
  event_t                    pend;

  logic [7:0]                cw, ch, csz;
  logic [3:0]                sc;
  logic [PARAM_W-1:0]        coord;
  logic [9:0]                org;
  logic [11:0]               off;
  logic [SIZE_W-1:0]         size;
  logic signed [PARAM_W:0]   mul_a;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [DIFF_W-1:0]  coord_s, prod_s, half_s, off_s, f_val, diff_c;
  logic [REM_W-1:0]          scaled_c;
  logic                      neg, over, ge;
  logic [2:0]                mods_c;
  logic                      pixel_hit;
  event_t                    cls;
  logic                      cls_drop;

  // Operand selection for the axis in progress.
  always_comb begin
    cw = (cfg.cell_size[7:0] == '0) ? 8'd1 : cfg.cell_size[7:0];
    ch = (cfg.cell_size[15:8] == '0) ? 8'd1 : cfg.cell_size[15:8];
    sc = (cfg.zoom == '0) ? 4'd1 : cfg.zoom;
    coord = axis ? rep.y : rep.x;
    org = axis ? cfg.image_row : cfg.image_col;
    csz = axis ? ch : cw;
    off = axis ? cfg.offset_y : cfg.offset_x;
    size = axis ? SIZE_W'(CANVAS_HEIGHT) : SIZE_W'(CANVAS_WIDTH);
  end

  // Per-axis arithmetic: product, offset subtraction, range check, divide step.
  always_comb begin
    mul_a = pixel_mode ? ($signed((PARAM_W+1)'(org)) - $signed((PARAM_W+1)'(1)))
                       : ($signed((PARAM_W+1)'(coord)) - $signed((PARAM_W+1)'(org)));
    prod_c = mul_a * $signed({1'b0, csz});
    coord_s = $signed(DIFF_W'(coord));
    prod_s = DIFF_W'(prod);
    half_s = $signed(DIFF_W'(csz >> 1));
    off_s = $signed(DIFF_W'(off));
    f_val = pixel_mode ? (coord_s - ONE_S - prod_s) : (prod_s + half_s);
    diff_c = f_val - off_s;
    scaled_c = REM_W'(size) * REM_W'(sc);
    neg = diff[DIFF_W-1];
    over = !neg && (diff[DIFF_W-2:0] >= (DIFF_W-1)'(scaled_c));
    ge = rem >= dvs;
  end

  // Report classification once both axes are mapped.
  always_comb begin
    mods_c = {rep.cb[CB_CTRL], rep.cb[CB_ALT], rep.cb[CB_SHIFT]};
    pixel_hit = !pixel_mode && (cfg.screen_cols != '0)
              && (rep.x > PARAM_W'(cfg.screen_cols) || rep.y > PARAM_W'(cfg.screen_rows));
    cls_drop = 1'b0;
    cls = '{kind: EV_MOVE, button: BUTTON_NONE, wheel: WHEEL_NONE, mods: mods_c,
            pos_x: POS_W'(gx), pos_y: POS_W'(res), in_view: vx & in_axis};
    if (rep.cb[CB_WHEEL]) begin
      // Horizontal wheel codes give no event.
      cls_drop = rep.cb[1:0] > 2'd1;
      cls.kind = EV_WHEEL;
      cls.wheel = (rep.cb[1:0] == 2'd0) ? WHEEL_UP : WHEEL_DOWN;
    end else if (rep.cb[CB_MOTION]) begin
      cls.kind = EV_MOVE;
      cls.button = rep.cb[1:0];
    end else begin
      cls_drop = rep.press && (rep.cb[1:0] == BUTTON_THREE);
      cls.kind = rep.press ? EV_PRESS : EV_RELEASE;
      cls.button = rep.cb[1:0];
    end
    q_pop = (state == M_IDLE) && !q_status.empty;
  end

  // Sequencer, position history and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      ev_valid <= 1'b0;
      pixel_mode <= 1'b0;
      last_x <= '0;
      last_y <= '0;
      last_visible <= 1'b0;
      axis <= 1'b0;
    end else begin
      // The emit state loads the output register itself.
      if (ev_valid && ev_ready && state != M_EMIT) ev_valid <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (!q_status.empty) begin
            rep <= q_head;
            state <= M_DECIDE;
          end
        end
        M_DECIDE: begin
          // The pixel mode latch is checked before any drop rule.
          if (pixel_hit) pixel_mode <= 1'b1;
          if (rep.cb[CB_LEAVE]) begin
            last_visible <= 1'b0;
            pend <= '{kind: EV_LEAVE, button: BUTTON_NONE, wheel: WHEEL_NONE,
                      mods: mods_c, pos_x: last_x, pos_y: last_y, in_view: 1'b0};
            state <= M_EMIT;
          end else if (rep.cb[CB_EXTRA] || rep.x == '0 || rep.y == '0) begin
            state <= M_IDLE;
          end else begin
            axis <= 1'b0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          prod <= prod_c;
          state <= M_ADD;
        end
        M_ADD: begin
          diff <= diff_c;
          state <= M_CHK;
        end
        M_CHK: begin
          in_axis <= !neg && !over;
          if (neg) begin
            res <= '0;
            state <= M_AXEND;
          end else if (over) begin
            res <= QUO_W'(size - 1'b1);
            state <= M_AXEND;
          end else begin
            rem <= diff[REM_W-1:0];
            dvs <= REM_W'(sc) << (QUO_W - 1);
            quo <= '0;
            step <= STEP_W'(QUO_W - 1);
            state <= M_DIV;
          end
        end
        M_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (ge) rem <= rem - dvs;
          quo <= {quo[QUO_W-2:0], ge};
          dvs <= dvs >> 1;
          if (step == '0) begin
            res <= {quo[QUO_W-2:0], ge};
            state <= M_AXEND;
          end else begin
            step <= step - 1'b1;
          end
        end
        M_AXEND: begin
          if (!axis) begin
            gx <= res;
            vx <= in_axis;
            axis <= 1'b1;
            state <= M_MUL;
          end else begin
            // The last position is kept even when the event is dropped.
            last_x <= POS_W'(gx);
            last_y <= POS_W'(res);
            last_visible <= vx & in_axis;
            pend <= cls;
            state <= cls_drop ? M_IDLE : M_EMIT;
          end
        end
        M_EMIT: begin
          if (!ev_valid || ev_ready) begin
            ev <= pend;
            ev_valid <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sgr_mouse_report_decoder_unit.sv
// Mouse report decoder for a raw terminal byte stream.
// The s_t* channel takes one received byte per transfer. The scanner looks for
// reports of the form ESC [ < cb ; x ; y M or m, skips other control
// sequences, and queues each complete report. The mapper turns a queued report
// into one event on the m_t* channel: kind in m_tuser, the rest in m_tdata.
// Bytes are taken one per cycle while the two-entry report queue has room.
// A report that is mapped goes from the queue head to the output register
// through two axes of multiply, subtract, range check and a restoring divide
// by the zoom factor; a clamped axis skips the divide. A leave report goes
// from the decide state straight to emit; a report with an extra button or
// a zero coordinate is dropped in the decide state. The output register
// holds its event while m_tready is low; the mapper then waits and the
// scanner keeps taking bytes until the queue fills, after which s_tready drops.
// The cfg_* port writes a register at any time that cfg_valid is high; it is
// meant to be used only while no report is in flight. Reset clears the
// scanner, queue, pixel mode latch and last position, and restores the
// register defaults.
module sgr_mouse_report_decoder_unit import smrd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,    // [7:0] data_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] button, [3:2] wheel_step, [6:4] modifiers, [15:7] pos_x,
  // [24:16] pos_y, [25] in_view, rest zero
  output logic [TDATA_W-1:0]     m_tdata,
  output logic [TUSER_W-1:0]     m_tuser,    // [2:0] event_kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t          cfg;
  queue_status_t q_status;
  logic          push, pop;
  report_t       push_data, q_head;
  event_t        ev;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{screen_cols: '0, screen_rows: '0, cell_size: 16'd257, image_col: '0,
               image_row: '0, zoom: 4'd1, offset_x: '0, offset_y: '0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TERM_COLS:  cfg.screen_cols <= cfg_data[9:0];
        CFG_TERM_ROWS:  cfg.screen_rows <= cfg_data[9:0];
        CFG_CELL_SIZE:  cfg.cell_size <= cfg_data;
        CFG_ORIGIN_COL: cfg.image_col <= cfg_data[9:0];
        CFG_ORIGIN_ROW: cfg.image_row <= cfg_data[9:0];
        CFG_ZOOM:       cfg.zoom <= cfg_data[3:0];
        CFG_OFFSET_X:   cfg.offset_x <= cfg_data[11:0];
        CFG_OFFSET_Y:   cfg.offset_y <= cfg_data[11:0];
      endcase
    end
  end

  smrd_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .byte_data  (s_tdata),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  smrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  smrd_mapper u_mapper (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .q_head   (q_head),
    .q_pop    (pop),
    .ev_valid (m_tvalid),
    .ev_ready (m_tready),
    .ev       (ev)
  );

  // Output packing.
  assign m_tdata = {(TDATA_W - TDATA_USED)'(0), ev.in_view, ev.pos_y, ev.pos_x,
                    ev.mods, ev.wheel, ev.button};
  assign m_tuser = ev.kind;

endmodule

// File: rtl/smrd_checker.sv
`include "sgr_mouse_report_decoder_unit_assert.svh"

module smrd_checker import smrd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [TUSER_W-1:0] m_tuser
);

  // Event kinds stay within the defined codes.
  `SMRD_ASSERT_IMPLY(a_kind_range, clk, rst, m_tvalid, m_tuser <= TUSER_W'(EV_LEAVE), "event kind out of range")

  // A leave event carries no button, no wheel step and is never in view.
  `SMRD_ASSERT_IMPLY(a_leave_fields, clk, rst, m_tvalid && m_tuser == TUSER_W'(EV_LEAVE), m_tdata[25] == 1'b0 && m_tdata[3:0] == 4'd0, "leave event with stray fields")

  // Positions are clamped to the canvas.
  `SMRD_ASSERT_IMPLY(a_pos_clamped, clk, rst, m_tvalid, m_tdata[15:7] <= POS_W'(CANVAS_WIDTH - 1) && m_tdata[24:16] <= POS_W'(CANVAS_HEIGHT - 1), "position beyond canvas")

  // Only wheel events carry a wheel step, and they always carry one.
  `SMRD_ASSERT_IMPLY(a_wheel_step, clk, rst, m_tvalid, (m_tuser == TUSER_W'(EV_WHEEL)) == (m_tdata[3:2] != 2'd0), "wheel step does not match event kind")

  // A stalled event is held unchanged.
  `SMRD_ASSERT_NEXT(a_hold_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "event changed while stalled")

endmodule

bind sgr_mouse_report_decoder_unit smrd_checker u_checker (.*);
